// ----- rtl/oaht_pkg.sv -----
// shared types, widths and status codes of the open-addressing hash table
package oaht_pkg;

    localparam int KEY_W         = 64;
    localparam int VAL_W         = 64;
    localparam int STATUS_W      = 3;
    localparam int OCC_W         = 5;
    localparam int SLOTS_DEFAULT = 16;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_NEW       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

    // request transaction
    typedef struct packed {
        logic             op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value_in;
    } in_t;

    // response transaction
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VAL_W-1:0]    value_out;
        logic [OCC_W-1:0]    occupied;
    } out_t;

    // one table slot as held in memory
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } slot_t;

endpackage

// ----- rtl/oaht_ram.sv -----
// generic single-write, single-read ram with registered read data
module oaht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     aclk,
    input  logic                                     wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/oaht_mod.sv -----
// home slot unit: key modulo the slot count, a mask or a folded reciprocal remainder
module oaht_mod #(
    parameter int SLOTS = oaht_pkg::SLOTS_DEFAULT
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     start,
    input  logic [oaht_pkg::KEY_W-1:0]               key,
    output logic                                     done,
    output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] rem
);

    localparam int IW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam bit IS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);

    generate
        if (IS_POW2) begin : g_mask
            logic          done_reg;
            logic [IW-1:0] rem_reg;

            // power of two: remainder is the low key bits
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    done_reg <= 1'b0;
                end else begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge aclk) begin
                if (start) begin
                    rem_reg <= key[IW-1:0];
                end
            end

            assign done = done_reg;
            assign rem  = rem_reg;
        end else begin : g_fold
            localparam int FOLDS = oaht_pkg::KEY_W / 8;
            localparam int PW    = 24;
            localparam int XW    = PW + $clog2(FOLDS);
            localparam int SHIFT = XW + IW;
            localparam logic [XW:0]   RECIP   = (XW + 1)'((64'd1 << SHIFT) / 64'(SLOTS));
            localparam logic [XW-1:0] SLOTS_X = XW'(SLOTS);

            logic [PW-1:0]  prod [FOLDS];
            logic [PW-1:0]  prod_reg [FOLDS];
            logic [XW-1:0]  sum_next;
            logic [XW-1:0]  sum_reg;
            logic [2*XW:0]  scaled;
            logic [XW-1:0]  q_reg;
            logic [XW-1:0]  diff;
            logic [IW-1:0]  rem_next;
            logic [IW-1:0]  rem_reg;
            logic           prod_vld_reg;
            logic           sum_vld_reg;
            logic           q_vld_reg;
            logic           done_reg;

            // fold: each key byte times its weight 2^(8k) mod SLOTS
            for (genvar g = 0; g < FOLDS; g++) begin : g_prod
                localparam logic [15:0] WEIGHT = 16'((64'd1 << (8 * g)) % 64'(SLOTS));
                assign prod[g] = {16'd0, key[8*g +: 8]} * {8'd0, WEIGHT};
            end

            // sum of the folded bytes, congruent to the key
            always_comb begin
                sum_next = '0;
                for (int j = 0; j < FOLDS; j++) begin
                    sum_next = sum_next + XW'(prod_reg[j]);
                end
            end

            // reciprocal quotient is low by at most one, one subtract fixes it
            assign scaled   = (2 * XW + 1)'(sum_reg) * (2 * XW + 1)'(RECIP);
            assign diff     = sum_reg - XW'(q_reg * SLOTS_X);
            assign rem_next = (diff >= SLOTS_X) ? IW'(diff - SLOTS_X) : IW'(diff);

            // stage valids
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    prod_vld_reg <= 1'b0;
                    sum_vld_reg  <= 1'b0;
                    q_vld_reg    <= 1'b0;
                    done_reg     <= 1'b0;
                end else begin
                    prod_vld_reg <= start;
                    sum_vld_reg  <= prod_vld_reg;
                    q_vld_reg    <= sum_vld_reg;
                    done_reg     <= q_vld_reg;
                end
            end

            // datapath
            always_ff @(posedge aclk) begin
                if (start) begin
                    prod_reg <= prod;
                end
                if (prod_vld_reg) begin
                    sum_reg <= sum_next;
                end
                if (sum_vld_reg) begin
                    q_reg <= XW'(scaled >> SHIFT);
                end
                if (q_vld_reg) begin
                    rem_reg <= rem_next;
                end
            end

            assign done = done_reg;
            assign rem  = rem_reg;
        end
    endgenerate

endmodule

// ----- rtl/open_address_hash_table_unit.sv -----
// top level: open-addressing hash table with quadratic probing
//
//  channel  | ports                          | moves
//  ---------+--------------------------------+------------------------------------
//  request  | s_valid s_ready s_data         | op, key, value_in
//  response | m_valid m_ready m_data         | status, value_out, occupied
//  config   | cfg_valid cfg_ready cfg_data   | zero key substitute, always ready
//
//  one transaction at a time; a full insert or a lookup on an empty table skips
//  hash and probe, others probe 1 to SLOTS slots after the hash,
//  one per cycle from the slot ram with the next read issued while checking.
//  hash waits on a mask register for power-of-two SLOTS, else on the folded unit.
//  after reset a clearing pass writes empty keys to every slot, s_ready low.
//  a held response does not block the next request from being taken.
module open_address_hash_table_unit #(
    parameter int SLOTS = oaht_pkg::SLOTS_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  oaht_pkg::in_t              s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output oaht_pkg::out_t             m_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [oaht_pkg::KEY_W-1:0] cfg_data
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [IW:0]   SLOTS_W    = (IW + 1)'(SLOTS);
    localparam logic [CW-1:0] SLOTS_C    = CW'(SLOTS);
    localparam logic [IW-1:0] LAST_SLOT  = IW'(SLOTS - 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_HASH  = 5'b00100,
        S_PROBE = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t                     state_reg, state_next;
    logic [oaht_pkg::KEY_W-1:0] subst_reg;
    logic [CW-1:0]              count_reg, count_next;
    logic [IW-1:0]              clr_reg, clr_next;
    logic [IW-1:0]              idx_reg, idx_next;
    logic [IW-1:0]              pos_reg, pos_next;
    logic [IW-1:0]              sq_reg, sq_next;
    logic [IW-1:0]              odd_reg, odd_next;
    logic                       op_reg;
    logic [oaht_pkg::KEY_W-1:0] key_reg;
    logic [oaht_pkg::VAL_W-1:0] val_reg;
    oaht_pkg::out_t             res_reg, res_next;
    logic                       m_valid_reg, m_valid_next;
    oaht_pkg::out_t             m_data_reg, m_data_next;

    logic                       accept;
    logic [oaht_pkg::KEY_W-1:0] eff_key;
    logic                       mod_start;
    logic                       mod_done;
    logic [IW-1:0]              mod_rem;

    logic                       ram_we;
    logic [IW-1:0]              ram_waddr;
    oaht_pkg::slot_t            ram_wdata;
    logic                       ram_re;
    logic [IW-1:0]              ram_raddr;
    oaht_pkg::slot_t            rd_slot;

    logic [IW:0]                pos_sum, sq_sum, odd_sum;
    logic [IW-1:0]              pos_step, sq_step, odd_step;
    logic                       slot_hit, slot_empty, ins_new;
    logic [CW+oaht_pkg::OCC_W-1:0] occ_ext;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // zero key stands for the substitute, never zero itself
    assign eff_key = (s_data.key != '0) ? s_data.key :
                     ((subst_reg != '0) ? subst_reg : oaht_pkg::KEY_W'(1));

    // quadratic probe step: pos + i*i and the running square, all mod SLOTS
    assign pos_sum  = {1'b0, pos_reg} + {1'b0, sq_reg};
    assign sq_sum   = {1'b0, sq_reg} + {1'b0, odd_reg};
    assign odd_sum  = {1'b0, odd_reg} + (IW + 1)'(2);
    assign pos_step = (pos_sum >= SLOTS_W) ? IW'(pos_sum - SLOTS_W) : pos_sum[IW-1:0];
    assign sq_step  = (sq_sum >= SLOTS_W) ? IW'(sq_sum - SLOTS_W) : sq_sum[IW-1:0];
    assign odd_step = (odd_sum >= SLOTS_W) ? IW'(odd_sum - SLOTS_W) : odd_sum[IW-1:0];

    // slot compare on the data read last cycle
    assign slot_hit   = (rd_slot.key == key_reg);
    assign slot_empty = (rd_slot.key == '0);
    assign ins_new    = (state_reg == S_PROBE) && (op_reg == oaht_pkg::OP_INSERT) &&
                        slot_empty;

    // occupancy reported on five bits
    assign occ_ext = (CW + oaht_pkg::OCC_W)'(count_next);

    oaht_mod #(
        .SLOTS (SLOTS)
    ) u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mod_start),
        .key     (eff_key),
        .done    (mod_done),
        .rem     (mod_rem)
    );

    oaht_ram #(
        .WIDTH ($bits(oaht_pkg::slot_t)),
        .DEPTH (SLOTS)
    ) u_slots (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (rd_slot)
    );

    // sequencer
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        clr_next     = clr_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        sq_next      = sq_reg;
        odd_next     = odd_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        mod_start    = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = pos_reg;
        ram_wdata    = '{key: key_reg, value: val_reg};
        ram_re       = 1'b0;
        ram_raddr    = pos_step;

        case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_SLOT) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    res_next.value_out = '0;
                    res_next.occupied  = occ_ext[oaht_pkg::OCC_W-1:0];
                    if (s_data.op == oaht_pkg::OP_INSERT && count_reg >= SLOTS_C) begin
                        res_next.status = oaht_pkg::ST_FULL;
                        state_next      = S_DONE;
                    end else if (s_data.op == oaht_pkg::OP_LOOKUP && count_reg == '0) begin
                        res_next.status = oaht_pkg::ST_NOT_FOUND;
                        state_next      = S_DONE;
                    end else begin
                        mod_start  = 1'b1;
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH: begin
                if (mod_done) begin
                    ram_re     = 1'b1;
                    ram_raddr  = mod_rem;
                    pos_next   = mod_rem;
                    sq_next    = '0;
                    odd_next   = IW'(1);
                    idx_next   = '0;
                    state_next = S_PROBE;
                end
            end
            S_PROBE: begin
                // next probe read goes out while this slot is checked
                ram_re             = 1'b1;
                res_next.value_out = '0;
                if (ins_new) begin
                    ram_we          = 1'b1;
                    count_next      = count_reg + 1'b1;
                    res_next.status = oaht_pkg::ST_NEW;
                    state_next      = S_DONE;
                end else if (op_reg == oaht_pkg::OP_INSERT && slot_hit) begin
                    ram_we          = 1'b1;
                    res_next.status = oaht_pkg::ST_UPDATED;
                    state_next      = S_DONE;
                end else if (op_reg == oaht_pkg::OP_LOOKUP && slot_hit) begin
                    res_next.status    = oaht_pkg::ST_FOUND;
                    res_next.value_out = rd_slot.value;
                    state_next         = S_DONE;
                end else if (idx_reg == LAST_SLOT) begin
                    res_next.status = (op_reg == oaht_pkg::OP_INSERT) ?
                                      oaht_pkg::ST_FULL : oaht_pkg::ST_NOT_FOUND;
                    state_next      = S_DONE;
                end else begin
                    pos_next = pos_step;
                    sq_next  = sq_step;
                    odd_next = odd_step;
                    idx_next = idx_reg + 1'b1;
                end
                res_next.occupied = occ_ext[oaht_pkg::OCC_W-1:0];
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            count_reg   <= '0;
            clr_reg     <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
            subst_reg   <= oaht_pkg::KEY_W'(1);
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            clr_reg     <= clr_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                subst_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= s_data.op;
            key_reg <= eff_key;
            val_reg <= s_data.value_in;
        end
        pos_reg    <= pos_next;
        sq_reg     <= sq_next;
        odd_reg    <= odd_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    // occupancy never passes capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= SLOTS_C)
        else $error("entry count above slot count");

    // remainder only completes while waiting for it
    a_mod_done_hash: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_done |-> (state_reg == S_HASH))
        else $error("home slot ready outside hash wait");

    // a new insert adds exactly one entry
    a_new_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        ins_new |=> (count_reg == CW'($past(count_reg) + 1'b1)))
        else $error("new insert did not bump the entry count");

    // requests are held off during the clearing pass
    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !s_ready)
        else $error("request taken while slots are being cleared");

    // slot writes only during clearing or a resolving probe
    a_write_window: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_CLEAR || state_reg == S_PROBE))
        else $error("slot write outside clear or probe");

endmodule
